// ----- design/pli_pkg.sv -----
// pli_pkg: shared types and codes for the piecewise linear interpolator.
// No dependencies; used by every design file through scoped names.
package pli_pkg;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int MAG_W   = 33;
    localparam int PROD_W  = 66;
    localparam int QUO_W   = 34;
    localparam int STEP_W  = 7;

    localparam logic       REQ_LOAD  = 1'b0;
    localparam logic       REQ_QUERY = 1'b1;

    localparam logic [1:0] STAT_INTERP = 2'd0;
    localparam logic [1:0] STAT_EXTRAP = 2'd1;
    localparam logic [1:0] STAT_ZDIV   = 2'd2;
    localparam logic [1:0] STAT_LOAD   = 2'd3;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         point_index;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
    } req_t;

    typedef struct packed {
        logic                     valid;
        req_t                     item;
    } queue_head_t;

endpackage

// ----- design/pli_front.sv -----
// pli_front: input side, unpacks stream transactions into request items
// and holds them in a two-entry queue. Depends on pli_pkg.
module pli_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [71:0]        s_tdata,
    input  logic [0:0]         s_tuser,
    output pli_pkg::queue_head_t head,
    input  logic               pop
);

    pli_pkg::req_t fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       do_pop;
    pli_pkg::req_t in_item;

    assign in_item.req_type    = s_tuser[0];
    assign in_item.point_index = s_tdata[5:0];
    assign in_item.x_value     = s_tdata[37:6];
    assign in_item.y_value     = s_tdata[69:38];

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- design/pli_back.sv -----
// pli_back: breakpoint tables, segment search, multiply, serial divide and
// the output register. Depends on pli_pkg.
module pli_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [6:0]           cfg_wdata,
    input  pli_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = (NW > pli_pkg::CNT_W) ? NW : pli_pkg::CNT_W;
    localparam int MW = pli_pkg::MAG_W;
    localparam int PW = pli_pkg::PROD_W;
    localparam int QW = pli_pkg::QUO_W;
    localparam int SW = pli_pkg::STEP_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_Q1, ST_Q2, ST_SCAN, ST_PICK, ST_EXACT, ST_SEG, ST_SEG1,
        ST_SEG2, ST_MUL0, ST_MUL1, ST_DIV, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg;

    logic signed [31:0] x_mem [MAX_POINTS];
    logic signed [31:0] y_mem [MAX_POINTS];
    logic signed [31:0] x_rd_reg;
    logic signed [31:0] y_rd_reg;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [CW-1:0]      idx_w;

    logic [6:0]         pc_reg;
    logic [CW-1:0]      pc_w;
    logic [NW-1:0]      n_pts;
    logic [NW-1:0]      dim;

    logic signed [31:0] cur_x_reg;
    logic signed [31:0] x0_reg;
    logic [AW-1:0]      k_reg;
    logic               a_hi_reg;
    logic               extrap_reg;
    logic [NW-1:0]      ic_reg;
    logic [NW-1:0]      cmp_idx_reg;
    logic               cmp_vld_reg;
    logic               match_reg;
    logic [AW-1:0]      midx_reg;
    logic signed [31:0] xk_reg;
    logic signed [31:0] yk_reg;
    logic signed [31:0] ya_reg;
    logic [MW-1:0]      dx_reg;
    logic [MW-1:0]      dy_reg;
    logic [MW-1:0]      t_reg;
    logic               neg_reg;
    logic               zdiv_reg;
    logic [PW-1:0]      prod_reg;
    logic [PW-1:0]      num_reg;
    logic [QW-1:0]      rem_reg;
    logic [QW-1:0]      q_reg;
    logic               big_reg;
    logic [SW-1:0]      step_reg;
    logic [31:0]        res_reg;
    logic [1:0]         status_reg;
    logic               sat_reg;
    logic               out_vld_reg;
    logic [31:0]        out_res_reg;
    logic [1:0]         out_status_reg;
    logic               out_sat_reg;

    // segment differences, 33-bit signed
    logic signed [MW-1:0] dx_s;
    logic signed [MW-1:0] dy_s;
    logic signed [MW-1:0] t_s;
    logic signed [31:0]   xa;
    logic [QW-1:0]        rem_sh;
    logic                 ge;
    logic signed [35:0]   sum;
    logic [49:0]          prod_lo_w;
    logic [48:0]          prod_hi_w;
    logic [PW-1:0]        prod_hi;

    assign pc_w  = CW'(pc_reg);
    assign n_pts = (pc_w < CW'(2)) ? NW'(2) :
                   (pc_w > CW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(pc_w);
    assign dim   = n_pts - NW'(1);

    assign pop    = (state_reg == ST_IDLE) && head.valid;
    assign idx_w  = CW'(head.item.point_index);
    assign mem_we = pop && (head.item.req_type == pli_pkg::REQ_LOAD)
                    && (idx_w < CW'(MAX_POINTS));

    always_comb
    begin
        rd_addr = '0;
        unique case (state_reg)
            ST_Q1:   rd_addr = dim[AW-1:0];
            ST_SCAN: rd_addr = ic_reg[AW-1:0];
            ST_PICK: rd_addr = midx_reg;
            ST_SEG:  rd_addr = k_reg;
            ST_SEG1: rd_addr = AW'(k_reg + AW'(1));
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[idx_w[AW-1:0]] <= head.item.x_value;
            y_mem[idx_w[AW-1:0]] <= head.item.y_value;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    assign xa     = a_hi_reg ? x_rd_reg : xk_reg;
    assign dx_s   = {x_rd_reg[31], x_rd_reg} - {xk_reg[31], xk_reg};
    assign dy_s   = {y_rd_reg[31], y_rd_reg} - {yk_reg[31], yk_reg};
    assign t_s    = {cur_x_reg[31], cur_x_reg} - {xa[31], xa};
    assign rem_sh = {rem_reg[QW-2:0], num_reg[PW-1]};
    assign ge     = rem_sh >= QW'(dx_reg);
    assign sum    = 36'(ya_reg) + (neg_reg ? -$signed({2'b00, q_reg})
                                           : $signed({2'b00, q_reg}));
    // 33x17 low half and 33x16 high half of the 66-bit product
    assign prod_lo_w = dy_reg * t_reg[16:0];
    assign prod_hi_w = dy_reg * t_reg[MW-1:17];
    assign prod_hi   = PW'(prod_hi_w) << 17;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= 7'd2;
            out_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
            if (out_vld_reg && m_tready && (state_reg != ST_OUT))
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head.valid)
                    begin
                        cur_x_reg <= head.item.x_value;
                        if (head.item.req_type == pli_pkg::REQ_LOAD)
                        begin
                            res_reg    <= '0;
                            status_reg <= pli_pkg::STAT_LOAD;
                            sat_reg    <= 1'b0;
                            state_reg  <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_Q1;
                        end
                    end
                end
                ST_Q1:
                begin
                    x0_reg    <= x_rd_reg;
                    state_reg <= ST_Q2;
                end
                ST_Q2:
                begin
                    ic_reg      <= '0;
                    cmp_vld_reg <= 1'b0;
                    match_reg   <= 1'b0;
                    // low end wins when both end tests hold
                    priority if (cur_x_reg <= x0_reg)
                    begin
                        k_reg      <= '0;
                        a_hi_reg   <= 1'b0;
                        extrap_reg <= 1'b1;
                        state_reg  <= ST_SEG;
                    end
                    else if (cur_x_reg >= x_rd_reg)
                    begin
                        k_reg      <= AW'(dim - NW'(1));
                        a_hi_reg   <= 1'b1;
                        extrap_reg <= 1'b1;
                        state_reg  <= ST_SEG;
                    end
                    else
                    begin
                        k_reg      <= '0;
                        a_hi_reg   <= 1'b0;
                        extrap_reg <= 1'b0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // issue one read per cycle, compare the previous one
                    if (ic_reg < n_pts)
                    begin
                        cmp_idx_reg <= ic_reg;
                        cmp_vld_reg <= 1'b1;
                        ic_reg      <= ic_reg + NW'(1);
                    end
                    else
                    begin
                        cmp_vld_reg <= 1'b0;
                    end
                    if (cmp_vld_reg)
                    begin
                        if (!match_reg && (x_rd_reg == cur_x_reg))
                        begin
                            match_reg <= 1'b1;
                            midx_reg  <= cmp_idx_reg[AW-1:0];
                        end
                        if ((cmp_idx_reg < dim) && (x_rd_reg < cur_x_reg))
                        begin
                            k_reg <= cmp_idx_reg[AW-1:0];
                        end
                        // last compare: all reads issued, valid already drops above
                        if (cmp_idx_reg == dim)
                        begin
                            state_reg <= ST_PICK;
                        end
                    end
                end
                ST_PICK:
                begin
                    state_reg <= match_reg ? ST_EXACT : ST_SEG;
                end
                ST_EXACT:
                begin
                    res_reg    <= y_rd_reg;
                    status_reg <= pli_pkg::STAT_INTERP;
                    sat_reg    <= 1'b0;
                    state_reg  <= ST_OUT;
                end
                ST_SEG:
                begin
                    state_reg <= ST_SEG1;
                end
                ST_SEG1:
                begin
                    xk_reg    <= x_rd_reg;
                    yk_reg    <= y_rd_reg;
                    state_reg <= ST_SEG2;
                end
                ST_SEG2:
                begin
                    ya_reg    <= a_hi_reg ? y_rd_reg : yk_reg;
                    dx_reg    <= dx_s[MW-1] ? MW'(-dx_s) : MW'(dx_s);
                    dy_reg    <= dy_s[MW-1] ? MW'(-dy_s) : MW'(dy_s);
                    t_reg     <= t_s[MW-1] ? MW'(-t_s) : MW'(t_s);
                    neg_reg   <= (dy_s[MW-1] ^ t_s[MW-1]) ^ dx_s[MW-1];
                    zdiv_reg  <= (dx_s == '0);
                    state_reg <= ST_MUL0;
                end
                ST_MUL0:
                begin
                    if (zdiv_reg)
                    begin
                        res_reg    <= '0;
                        status_reg <= pli_pkg::STAT_ZDIV;
                        sat_reg    <= 1'b0;
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        prod_reg  <= PW'(prod_lo_w);
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                begin
                    num_reg   <= prod_reg + prod_hi;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    big_reg   <= 1'b0;
                    step_reg  <= SW'(PW - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // restoring divide, one numerator bit per cycle
                    rem_reg <= ge ? (rem_sh - QW'(dx_reg)) : rem_sh;
                    num_reg <= {num_reg[PW-2:0], 1'b0};
                    q_reg   <= {q_reg[QW-2:0], ge && (step_reg < SW'(QW))};
                    if (ge && (step_reg >= SW'(QW)))
                    begin
                        big_reg <= 1'b1;
                    end
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        step_reg <= step_reg - SW'(1);
                    end
                end
                ST_FIN:
                begin
                    status_reg <= extrap_reg ? pli_pkg::STAT_EXTRAP
                                             : pli_pkg::STAT_INTERP;
                    priority if (big_reg)
                    begin
                        res_reg <= neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        sat_reg <= 1'b1;
                    end
                    else if (sum > 36'sh0_7FFF_FFFF)
                    begin
                        res_reg <= 32'h7FFF_FFFF;
                        sat_reg <= 1'b1;
                    end
                    else if (sum < -36'sh0_8000_0000)
                    begin
                        res_reg <= 32'h8000_0000;
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        res_reg <= sum[31:0];
                        sat_reg <= 1'b0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_vld_reg || m_tready)
                    begin
                        out_vld_reg    <= 1'b1;
                        out_res_reg    <= res_reg;
                        out_status_reg <= status_reg;
                        out_sat_reg    <= sat_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_sat_reg, out_status_reg, out_res_reg};

endmodule

// ----- design/piecewise_linear_interpolator_core.sv -----
// Piecewise linear interpolator with end-segment extrapolation.
//
// Slave stream: tuser[0] = req_type (0 load, 1 query); tdata carries
// point_index, x_value, y_value (Q16.16). Master stream: one result per
// transaction with result_y, status and saturated.
// cfg_we/cfg_wdata set point_count (clamped to 2..MAX_POINTS); the user must
// write it only while idle, which the block does not enforce. A load returns
// a zero result. A query at the table ends skips the scan, an interior point
// scans; off a breakpoint both go to the multiply and 66-step serial divider.
// The table scan reads one entry per cycle from the single memory port and
// the divider retires one quotient bit per cycle, so these set the rate.
// Items are processed one at a time; a two-entry input queue keeps
// accepting while a result waits. A stalled master holds its result and
// the engine waits in its output state. Reset clears control state and
// sets point_count to 2; table contents are undefined until loaded.
// Depends on pli_pkg, pli_front, pli_back.
module piecewise_linear_interpolator_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // point_index[5:0], x_value[37:6], y_value[69:38]
    input  logic [0:0]  s_tuser,  // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // result_y[31:0], status[33:32], saturated[34]
);

    pli_pkg::queue_head_t head;
    logic                 pop;

    pli_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    pli_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- design/pli_checker.sv -----
// pli_checker: port-level assertions for the interpolator core, bound to
// the top level. Depends on pli_pkg.
module pli_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [6:0]  cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == pli_pkg::STAT_LOAD)
        |-> (m_tdata[31:0] == 32'h0) && !m_tdata[34])
        else $error("load transaction with nonzero result");

    a_zdiv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == pli_pkg::STAT_ZDIV)
        |-> (m_tdata[31:0] == 32'h0) && !m_tdata[34])
        else $error("zero divisor with nonzero result");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34]
        |-> (m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000))
        else $error("saturated result off the rails");

endmodule

bind piecewise_linear_interpolator_core pli_checker u_pli_checker (.*);
